### hdl/pclu_pkg.sv
// Shared types and constants for the palette fade color lookup unit.
// No dependencies; every other file imports this package.

package pclu_pkg;

    localparam int CHAN_W     = 8;
    localparam int FACTOR_W   = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 120;

    localparam logic [FACTOR_W-1:0] FADE_FACTOR_RST = 9'd256;
    localparam logic [FACTOR_W-1:0] FADE_LIMIT_RST  = 9'd256;
    localparam logic [15:0]         QUARTER_MASK    = 16'h39e7;
    localparam logic [15:0]         PAIR_MASK       = 16'h1863;
    localparam logic [7:0]          ALPHA_OPAQUE    = 8'hff;

    typedef enum logic {
        MODE_WRITE  = 1'b0,
        MODE_LOOKUP = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_FACTOR = 1'b0,
        CFG_FADE_LIMIT  = 1'b1
    } cfg_reg_t;

    // Red sits in the lowest byte.
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    // The last field sits in the lowest bits.
    typedef struct packed {
        logic [5:0]  blue_six;
        logic [5:0]  green_six;
        logic [5:0]  red_six;
        logic [31:0] interp_pair;
        logic [15:0] quarter_word;
        logic [15:0] rgb565_word;
        logic [31:0] rgba_word;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

### hdl/pclu_fade.sv
// Brightness scaling of one color on palette write, with saturation.
// Depends on pclu_pkg.

module pclu_fade (
    input  pclu_pkg::rgb_t                      color_in,
    input  logic [pclu_pkg::FACTOR_W-1:0]       fade_factor,
    output pclu_pkg::rgb_t                      color_out
);
    import pclu_pkg::*;

    localparam int PROD_W = CHAN_W + FACTOR_W;

    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [FACTOR_W-1:0] f);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(c) * PROD_W'(f);
        if (prod[PROD_W-1]) begin
            return '1;
        end
        return prod[PROD_W-2:CHAN_W];
    endfunction

    always_comb begin
        color_out.red   = scale_chan(color_in.red,   fade_factor);
        color_out.green = scale_chan(color_in.green, fade_factor);
        color_out.blue  = scale_chan(color_in.blue,  fade_factor);
    end

endmodule

### hdl/pclu_store.sv
// Palette color memory: one write port, one registered read port, and a
// valid bit per entry so that unwritten entries read as black. Depends on pclu_pkg.

module pclu_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  pclu_pkg::rgb_t      wr_color,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output pclu_pkg::rgb_t      rd_color
);
    import pclu_pkg::*;

    rgb_t             color_mem_reg [DEPTH];
    logic [DEPTH-1:0] entry_valid_reg;
    rgb_t             rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            color_mem_reg[wr_addr] <= wr_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (wr_en) begin
            entry_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= color_mem_reg[rd_addr];
            rd_valid_reg <= entry_valid_reg[rd_addr];
        end
    end

    assign rd_color = rd_valid_reg ? rd_data_reg : '0;

    // Entries are never invalidated once written.
    a_valid_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> $countones(entry_valid_reg) >= $past($countones(entry_valid_reg)))
        else $error("palette valid bits decreased outside reset");

endmodule

### hdl/pclu_format.sv
// Conversion of one palette color into its display forms.
// Depends on pclu_pkg.

module pclu_format (
    input  pclu_pkg::rgb_t     color,
    output pclu_pkg::result_t  result
);
    import pclu_pkg::*;

    logic [15:0] w565;
    logic [15:0] quarter;

    always_comb begin
        w565    = {color.red[7:3], color.green[7:2], color.blue[7:3]};
        quarter = (w565 >> 2) & QUARTER_MASK;

        result.rgba_word    = {ALPHA_OPAQUE, color.blue, color.green, color.red};
        result.rgb565_word  = w565;
        result.quarter_word = quarter;
        result.interp_pair  = {w565 & PAIR_MASK, quarter};
        result.red_six      = color.red[7:2];
        result.green_six    = color.green[7:2];
        result.blue_six     = color.blue[7:2];
    end

endmodule

### hdl/palette_fade_color_lookup_unit.sv
// Palette fade color lookup unit, top level. Uses pclu_pkg, pclu_fade, pclu_store
// and pclu_format.
//
// The unit takes one beat per clock while the result side is not stalled and returns one
// result beat per input beat. The palette memory has a single write and a single registered
// read port. Each beat writes its entry in the input stage, faded if its index is below the
// fade limit, or only addresses it; the registered read data or write data is converted in
// the conversion stage, and the output register holds the result. A write beat returns the
// entry as stored; an index at or beyond PALETTE_SIZE writes nothing and returns black.
// All entries read as black after reset.

module palette_fade_color_lookup_unit #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [pclu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pclu_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // Input beats.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // entry_index [7:0], red_in [15:8], green_in [23:16], blue_in [31:24]
    input  logic [pclu_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode [0]
    input  logic                               s_tuser,
    // Result beats.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // rgba_word [31:0], rgb565_word [47:32], quarter_word [63:48], interp_pair [95:64],
    // red_six [101:96], green_six [107:102], blue_six [113:108], zero [119:114]
    output logic [pclu_pkg::M_TDATA_W-1:0]     m_tdata
);
    import pclu_pkg::*;

    localparam int            ADDR_W   = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam logic [8:0]    SIZE_LIM = 9'(PALETTE_SIZE);

    logic [FACTOR_W-1:0] fade_factor_reg;
    logic [FACTOR_W-1:0] fade_limit_reg;

    logic        adv;

    logic        a_valid_reg;
    mode_t       a_mode_reg;
    logic [7:0]  a_idx_reg;
    rgb_t        a_color_reg;

    logic        a_in_range;
    logic        a_faded;
    logic        a_write;
    rgb_t        a_scaled;
    rgb_t        a_wr_color;

    logic        b_valid_reg;
    logic        b_range_reg;
    logic        b_write_reg;
    rgb_t        b_color_reg;
    rgb_t        b_rd_color;
    rgb_t        b_entry;
    result_t     b_result;

    logic        m_valid_reg;
    result_t     m_result_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_factor_reg <= FADE_FACTOR_RST;
            fade_limit_reg  <= FADE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FADE_FACTOR: fade_factor_reg <= cfg_wr_data;
                CFG_FADE_LIMIT:  fade_limit_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_mode_reg        <= mode_t'(s_tuser);
            a_idx_reg         <= s_tdata[7:0];
            a_color_reg.red   <= s_tdata[15:8];
            a_color_reg.green <= s_tdata[23:16];
            a_color_reg.blue  <= s_tdata[31:24];
        end
    end

    pclu_fade u_fade (
        .color_in    (a_color_reg),
        .fade_factor (fade_factor_reg),
        .color_out   (a_scaled)
    );

    always_comb begin
        a_in_range = {1'b0, a_idx_reg} < SIZE_LIM;
        a_faded    = {1'b0, a_idx_reg} < fade_limit_reg;
        a_write    = a_in_range && (a_mode_reg == MODE_WRITE);
        a_wr_color = a_faded ? a_scaled : a_color_reg;
    end

    pclu_store #(
        .DEPTH  (PALETTE_SIZE),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (adv && a_valid_reg && a_write),
        .wr_addr  (a_idx_reg[ADDR_W-1:0]),
        .wr_color (a_wr_color),
        .rd_en    (adv),
        .rd_addr  (a_idx_reg[ADDR_W-1:0]),
        .rd_color (b_rd_color)
    );

    // Conversion stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_range_reg <= a_in_range;
            b_write_reg <= a_write;
            b_color_reg <= a_wr_color;
        end
    end

    always_comb begin
        priority if (!b_range_reg) begin
            b_entry = '0;
        end else if (b_write_reg) begin
            b_entry = b_color_reg;
        end else begin
            b_entry = b_rd_color;
        end
    end

    pclu_format u_format (
        .color  (b_entry),
        .result (b_result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_result_reg <= b_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), m_result_reg};

    a_alpha_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_result_reg.rgba_word[31:24] == ALPHA_OPAQUE)
        else $error("result beat without opaque alpha");

    a_quarter_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_result_reg.interp_pair[15:0] == m_result_reg.quarter_word &&
                        m_result_reg.quarter_word ==
                        ((m_result_reg.rgb565_word >> 2) & QUARTER_MASK))
        else $error("interpolation words disagree with rgb565 word");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && adv |=> m_valid_reg)
        else $error("beat lost between conversion stage and output register");

endmodule
